// ----- rtl/bf3_pkg.sv -----
// ----------------------------------------------------------------------------
// bf3_pkg - shared types and constants for the 3x3 box filter
// Field widths, register codes, reset values and the reciprocal used for the
// divide by nine.
// ----------------------------------------------------------------------------
package bf3_pkg;

	// Pixel and register field widths
	localparam int PIX_W  = 8;
	localparam int COLS_W = 11;
	localparam int ROWS_W = 13;

	// Default frame limits (top level parameters)
	localparam int DEF_MAX_COLS = 1024;
	localparam int DEF_MAX_ROWS = 4096;

	// Register reset values
	localparam int RESET_COLS = 640;
	localparam int RESET_ROWS = 480;

	// APB port geometry: two 32-bit registers at byte offsets 0 and 4
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	typedef enum logic {
		REG_COLS = 1'b0,
		REG_ROWS = 1'b1
	} reg_idx_t;

	// Input word function code
	typedef enum logic {
		FUNC_PIXEL = 1'b0,
		FUNC_FLUSH = 1'b1
	} func_t;

	// Window sum of nine 8-bit pixels
	localparam int SUM_W = 12;

	// floor(x / 9) == (x * 7282) >> 16 for every x below 32760
	localparam int                RECIP_W     = 13;
	localparam logic [RECIP_W-1:0] RECIP_9    = 13'd7282;
	localparam int                RECIP_SHIFT = 16;

endpackage

// ----- rtl/bf3_ifs.sv -----
// ----------------------------------------------------------------------------
// bf3_ifs - stream channels of the 3x3 box filter
// Pixel input channel and filtered pixel output channel, valid/ready.
// ----------------------------------------------------------------------------

// Input pixel stream
interface bf3_in_if
	import bf3_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             func;
	logic [PIX_W-1:0] pixel_in;

	modport source (output valid, output func, output pixel_in, input ready);
	modport sink   (input valid, input func, input pixel_in, output ready);
endinterface

// Filtered pixel stream
interface bf3_out_if
	import bf3_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic             frame_last;

	modport source (output valid, output pixel_out, output frame_last, input ready);
	modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

// ----- rtl/box_filter_3x3_gray_core.sv -----
// ----------------------------------------------------------------------------
// box_filter_3x3_gray_core - streaming 3x3 mean filter, 8-bit grayscale
// Raster-order pixels in, raster-order filtered pixels out. Border pixels are
// copied, interior pixels are floor(sum of 3x3 / 9).
// ----------------------------------------------------------------------------
//  channel   dir  handshake      word
//  pixels    in   valid/ready    func, pixel_in
//  results   out  valid/ready    pixel_out, frame_last
//  apb       in   psel/penable   image_cols (0x0), image_rows (0x4)
//
//  One word per clock sustained while the output is not stalled; a result is
//  registered after the input, window, adder tree and reciprocal multiply.
//  The line store has one write and two read ports, read data registered.
//  pixels.ready drops only while the output register holds a stalled word.
//  arst_n clears control state and the window; the line store is not cleared.
//  A register write restarts the frame; the line store is kept.
// ----------------------------------------------------------------------------
module box_filter_3x3_gray_core
	import bf3_pkg::*;
#(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  logic              clk,
	input  logic              arst_n,
	bf3_in_if.sink            pixels,
	bf3_out_if.source         results,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int CW    = $clog2(MAX_COLS + 1);
	localparam int RW    = $clog2(MAX_ROWS + 1);
	localparam int PW    = CW + RW;
	localparam int AW    = $clog2(2 * MAX_COLS + 1);
	localparam int DEPTH = 1 << AW;
	localparam int PRODW = SUM_W + RECIP_W;

	function automatic logic [CW-1:0] clamp_cols(logic [COLS_W-1:0] v);
		logic [CW-1:0] r;
		if (v == '0) begin
			r = CW'(1);
		end else if (int'(v) > MAX_COLS) begin
			r = CW'(MAX_COLS);
		end else begin
			r = CW'(v);
		end
		return r;
	endfunction

	function automatic logic [RW-1:0] clamp_rows(logic [ROWS_W-1:0] v);
		logic [RW-1:0] r;
		if (v == '0) begin
			r = RW'(1);
		end else if (int'(v) > MAX_ROWS) begin
			r = RW'(MAX_ROWS);
		end else begin
			r = RW'(v);
		end
		return r;
	endfunction

	// Configuration
	logic [COLS_W-1:0] cols_q, cols_d;
	logic [ROWS_W-1:0] rows_q, rows_d;
	logic [PW-1:0]     total_q;
	logic [CW-1:0]     cols_eff;
	logic [RW-1:0]     rows_eff;
	logic              cfg_wr;
	reg_idx_t          cfg_idx;

	// Frame position state
	logic [AW-1:0]     wp_q;
	logic [PW-1:0]     in_count_q;
	logic [CW-1:0]     out_col_q;
	logic [RW-1:0]     out_row_q;
	logic [AW-1:0]     out_addr_q;

	// Line store
	logic [PIX_W-1:0]  line_q [DEPTH];
	logic [AW-1:0]     addr_a, addr_b;

	// Accept decode
	logic              acc, is_pix, in_done, wr_en, emit, o_last, o_border;
	logic              rdy1, rdy2, rdy3, rdy_o;

	// Stage 1
	logic              v_s1, shift_s1, emit_s1, flush_s1, border_s1, last_s1;
	logic [PIX_W-1:0]  pix_s1, ra_s1, rb_s1;

	// Stage 2 and window
	logic              v_s2, flush_s2, border_s2, last_s2;
	logic [PIX_W-1:0]  fpix_s2;
	logic [PIX_W-1:0]  win_q [3][3];
	logic [SUM_W-1:0]  win_sum;

	// Stage 3
	logic              v_s3, copy_s3, last_s3;
	logic [SUM_W-1:0]  sum_s3;
	logic [PIX_W-1:0]  cpix_s3;
	logic [PRODW-1:0]  prod;

	// Output register
	logic              out_valid_q, out_last_q;
	logic [PIX_W-1:0]  out_pix_q;

	// APB decode and readback
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_comb begin
		cols_d = cols_q;
		rows_d = rows_q;
		if (cfg_wr) begin
			case (cfg_idx)
				REG_COLS: cols_d = pwdata[COLS_W-1:0];
				REG_ROWS: rows_d = pwdata[ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_COLS: prdata = APB_DW'(cols_q);
			REG_ROWS: prdata = APB_DW'(rows_q);
			default:  prdata = '0;
		endcase
	end

	assign cols_eff = clamp_cols(cols_q);
	assign rows_eff = clamp_rows(rows_q);

	// Handshake chain: each stage moves when the one after it has room
	assign rdy_o        = !out_valid_q || results.ready;
	assign rdy3         = !v_s3 || rdy_o;
	assign rdy2         = !v_s2 || rdy3;
	assign rdy1         = !v_s1 || rdy2;
	assign pixels.ready = rdy1;

	// Accept decode: write, emit and position of the pending output
	assign acc      = pixels.valid && rdy1;
	assign is_pix   = (pixels.func == FUNC_PIXEL);
	assign in_done  = (in_count_q == total_q);
	assign wr_en    = acc && is_pix && !in_done;
	assign emit     = acc && ((is_pix && !in_done && (in_count_q > PW'(cols_eff)))
		|| (!is_pix && in_done));
	assign o_last   = (out_col_q == cols_eff - CW'(1)) && (out_row_q == rows_eff - RW'(1));
	assign o_border = (out_col_q == '0) || (out_col_q == cols_eff - CW'(1))
		|| (out_row_q == '0) || (out_row_q == rows_eff - RW'(1));

	// Rows above the newest pixel; a flush reads the pending pixel itself
	assign addr_a = is_pix ? (wp_q - AW'(cols_eff)) : out_addr_q;
	assign addr_b = wp_q - (AW'(cols_eff) << 1);

	// Line store ring
	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_q[wp_q] <= pixels.pixel_in;
		end
		if (acc) begin
			ra_s1 <= line_q[addr_a];
			rb_s1 <= line_q[addr_b];
		end
	end

	// Control state, positions and window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q      <= COLS_W'(RESET_COLS);
			rows_q      <= ROWS_W'(RESET_ROWS);
			total_q     <= PW'(clamp_cols(COLS_W'(RESET_COLS)))
				* PW'(clamp_rows(ROWS_W'(RESET_ROWS)));
			wp_q        <= '0;
			in_count_q  <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_addr_q  <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < 3; c++) begin
				for (int r = 0; r < 3; r++) begin
					win_q[c][r] <= '0;
				end
			end
		end else begin
			cols_q  <= cols_d;
			rows_q  <= rows_d;
			total_q <= PW'(clamp_cols(cols_d)) * PW'(clamp_rows(rows_d));

			// frame positions
			if (cfg_wr) begin
				in_count_q <= '0;
				out_col_q  <= '0;
				out_row_q  <= '0;
				out_addr_q <= wp_q;
			end else begin
				if (wr_en) begin
					wp_q       <= wp_q + AW'(1);
					in_count_q <= in_count_q + PW'(1);
				end
				if (emit) begin
					if (o_last) begin
						in_count_q <= '0;
						out_col_q  <= '0;
						out_row_q  <= '0;
						out_addr_q <= wp_q;
					end else begin
						out_addr_q <= out_addr_q + AW'(1);
						if (out_col_q == cols_eff - CW'(1)) begin
							out_col_q <= '0;
							out_row_q <= out_row_q + RW'(1);
						end else begin
							out_col_q <= out_col_q + CW'(1);
						end
					end
				end
			end

			// stage valids
			if (rdy1) begin
				v_s1 <= wr_en || emit;
			end
			if (rdy2) begin
				v_s2 <= v_s1 && emit_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy_o) begin
				out_valid_q <= v_s3;
			end

			// window shifts once per written pixel, newest column last
			if (rdy2 && v_s1 && shift_s1) begin
				for (int c = 0; c < 2; c++) begin
					for (int r = 0; r < 3; r++) begin
						win_q[c][r] <= win_q[c+1][r];
					end
				end
				win_q[2][0] <= rb_s1;
				win_q[2][1] <= ra_s1;
				win_q[2][2] <= pix_s1;
			end
		end
	end

	// Window sum
	always_comb begin
		win_sum = '0;
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				win_sum = win_sum + SUM_W'(win_q[c][r]);
			end
		end
	end

	// Divide by nine through the reciprocal
	assign prod = PRODW'(sum_s3) * PRODW'(RECIP_9);

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1    <= pixels.pixel_in;
			shift_s1  <= wr_en;
			emit_s1   <= emit;
			flush_s1  <= !is_pix;
			border_s1 <= o_border;
			last_s1   <= o_last;
		end
		if (rdy2 && v_s1) begin
			flush_s2  <= flush_s1;
			border_s2 <= border_s1;
			last_s2   <= last_s1;
			fpix_s2   <= ra_s1;
		end
		if (rdy3 && v_s2) begin
			sum_s3  <= win_sum;
			copy_s3 <= flush_s2 || border_s2;
			cpix_s3 <= flush_s2 ? fpix_s2 : win_q[1][1];
			last_s3 <= last_s2;
		end
		if (rdy_o && v_s3) begin
			out_pix_q  <= copy_s3 ? cpix_s3 : prod[RECIP_SHIFT +: PIX_W];
			out_last_q <= last_s3;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.pixel_out  = out_pix_q;
	assign results.frame_last = out_last_q;

endmodule

// ----- rtl/bf3_checker.sv -----
// ----------------------------------------------------------------------------
// bf3_checker - port-level checks for the 3x3 box filter
// Watches the stream and register ports of the top level; bound below.
// ----------------------------------------------------------------------------
module bf3_checker
	import bf3_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [PIX_W-1:0]  pixel_out,
	input logic              frame_last,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [APB_AW-1:0] paddr,
	input logic [APB_DW-1:0] pwdata,
	input logic [APB_DW-1:0] prdata
);

	// Input only stalls behind a stalled output word
	a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled while output side can drain");

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(pixel_out)
		&& $stable(frame_last)))
		else $error("result word changed while stalled");

	// Column count reads back what was written
	a_cols_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[2] == REG_COLS)
		|=> (paddr[2] != REG_COLS || prdata == APB_DW'($past(pwdata[COLS_W-1:0]))))
		else $error("image_cols readback mismatch");

	// Row count reads back what was written
	a_rows_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[2] == REG_ROWS)
		|=> (paddr[2] != REG_ROWS || prdata == APB_DW'($past(pwdata[ROWS_W-1:0]))))
		else $error("image_rows readback mismatch");

endmodule

bind box_filter_3x3_gray_core bf3_checker u_bf3_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (pixels.ready),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.pixel_out  (results.pixel_out),
	.frame_last (results.frame_last),
	.psel       (psel),
	.penable    (penable),
	.pwrite     (pwrite),
	.paddr      (paddr),
	.pwdata     (pwdata),
	.prdata     (prdata)
);

// ----- test/box_filter_3x3_gray_core_tb.sv -----
// ----------------------------------------------------------------------------
// box_filter_3x3_gray_core_tb - self-checking bench for the 3x3 mean filter
// A class tracks the filter state for every accepted input word and queues
// the pixels it should produce. Output words are compared against that queue.
// Frames of many sizes are run, including clamped register values, restarts,
// ignored flushes and extra pixels. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module box_filter_3x3_gray_core_tb;
	import bf3_pkg::*;

	localparam int RING_N      = 2 * DEF_MAX_COLS + 4;
	localparam int MAX_REPORTS = 100;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_LAT   = 10;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             last;
	} filt_word_t;

	// Tracks the filter state and holds the pixels still owed by the block
	class mean_filter_model;
		logic [PIX_W-1:0]  ring [RING_N];
		int unsigned       wr_ptr, in_col, in_row, out_pos;
		logic [COLS_W-1:0] cols_reg;
		logic [ROWS_W-1:0] rows_reg;
		filt_word_t        expected_pixels [$];
		int                errors, checked, frames, words;

		function new();
			foreach (ring[i]) ring[i] = '0;
			wr_ptr = 0;
			cols_reg = COLS_W'(RESET_COLS);
			rows_reg = ROWS_W'(RESET_ROWS);
			errors = 0;
			checked = 0;
			frames = 0;
			words = 0;
			restart();
		endfunction

		function void restart();
			in_col = 0;
			in_row = 0;
			out_pos = 0;
		endfunction

		function int unsigned cols_eff();
			if (cols_reg == 0) return 1;
			if (cols_reg > DEF_MAX_COLS) return DEF_MAX_COLS;
			return 32'(cols_reg);
		endfunction

		function int unsigned rows_eff();
			if (rows_reg == 0) return 1;
			if (rows_reg > DEF_MAX_ROWS) return DEF_MAX_ROWS;
			return 32'(rows_reg);
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction

		function void note_error(string msg);
			errors++;
			if (errors <= MAX_REPORTS) $display("%s", msg);
		endfunction

		// pixel written 'back' words before the newest one
		function logic [PIX_W-1:0] fetch(int unsigned back);
			return ring[(wr_ptr + RING_N - 1 - (back % RING_N)) % RING_N];
		endfunction

		// queue the pixel at out_pos; newest = raster index of newest input
		function void emit(int unsigned newest);
			int unsigned c_n, r_n, total, r, c, sum, i, j;
			filt_word_t w;
			c_n = cols_eff();
			r_n = rows_eff();
			total = c_n * r_n;
			r = out_pos / c_n;
			c = out_pos % c_n;
			if (c == 0 || c == c_n - 1 || r == 0 || r == r_n - 1) begin
				w.pixel = fetch(newest - out_pos);
			end else begin
				sum = 0;
				for (i = 0; i < 3; i++)
					for (j = 0; j < 3; j++)
						sum += fetch(newest - ((r - 1 + i) * c_n + (c - 1 + j)));
				w.pixel = PIX_W'(sum / 9);
			end
			w.last = (out_pos == total - 1);
			expected_pixels.push_back(w);
			out_pos++;
			if (w.last) restart();
		endfunction

		function void write_reg(reg_idx_t idx, logic [APB_DW-1:0] v);
			case (idx)
				REG_COLS: cols_reg = v[COLS_W-1:0];
				REG_ROWS: rows_reg = v[ROWS_W-1:0];
				default: ;
			endcase
			restart();
		endfunction

		// one accepted input word
		function void take_word(func_t f, logic [PIX_W-1:0] p);
			int unsigned c_n, r_n, total, cnt;
			words++;
			c_n = cols_eff();
			r_n = rows_eff();
			total = c_n * r_n;
			if (f == FUNC_PIXEL) begin
				// extra pixels past the end of the frame are dropped
				if (in_row >= r_n) return;
				ring[wr_ptr] = p;
				wr_ptr = (wr_ptr + 1) % RING_N;
				in_col++;
				if (in_col >= c_n) begin
					in_col = 0;
					in_row++;
				end
				cnt = in_row * c_n + in_col;
				if (cnt >= c_n + 2 && out_pos < total) emit(cnt - 1);
			end else begin
				// flush only counts once the whole frame is in
				if (in_row < r_n || out_pos >= total) return;
				emit(total - 1);
			end
		endfunction

		function void check_pixel(logic [PIX_W-1:0] p, logic l);
			filt_word_t w;
			if (expected_pixels.size() == 0) begin
				note_error($sformatf("%0t: unexpected word pixel_out %0d frame_last %0b",
					$time, p, l));
				return;
			end
			w = expected_pixels.pop_front();
			checked++;
			if (w.last) frames++;
			if (p !== w.pixel)
				note_error($sformatf("%0t: pixel_out expected %0d actual %0d",
					$time, w.pixel, p));
			if (l !== w.last)
				note_error($sformatf("%0t: frame_last expected %0b actual %0b",
					$time, w.last, l));
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel, penable, pwrite, pready;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata, prdata;

	bf3_in_if  pix_ch ();
	bf3_out_if res_ch ();

	mean_filter_model model = new();

	bit idle_on   = 1'b1;
	bit stall_on  = 1'b1;
	bit sink_hold = 1'b0;
	int counted   = 0;

	box_filter_3x3_gray_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixels  (pix_ch.sink),
		.results (res_ch.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// overall time limit
	initial begin
		#2000000;
		$display("timeout: block stopped producing words");
		$display("simulation failed");
		$finish;
	end

	// accepted words on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_ch.valid && pix_ch.ready)
				model.take_word(func_t'(pix_ch.func), pix_ch.pixel_in);
			if (res_ch.valid && res_ch.ready)
				model.check_pixel(res_ch.pixel_out, res_ch.frame_last);
		end
	end

	// receiver: short random stalls, one long hold-off on request
	initial begin
		res_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (sink_hold) begin
				sink_hold = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (stall_on && $urandom_range(0, 3) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic sender_gap();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			pix_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// offer one word and wait until it is taken
	task automatic send_word(func_t f, logic [PIX_W-1:0] p);
		sender_gap();
		pix_ch.valid    <= 1'b1;
		pix_ch.func     <= f;
		pix_ch.pixel_in <= p;
		do @(posedge clk); while (!pix_ch.ready);
	endtask

	task automatic wait_drained();
		pix_ch.valid <= 1'b0;
		do @(posedge clk); while (model.pending() != 0);
	endtask

	// APB write followed by a read back of the same register
	task automatic program_reg(reg_idx_t idx, logic [APB_DW-1:0] v);
		logic [APB_DW-1:0] want;
		want = (idx == REG_COLS) ? APB_DW'(v[COLS_W-1:0]) : APB_DW'(v[ROWS_W-1:0]);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'({idx, 2'b00});
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		model.write_reg(idx, v);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want)
			model.note_error($sformatf("%0t: prdata at %0d expected %0d actual %0d",
				$time, idx, want, prdata));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// reconfigure only once the pipeline is empty
	task automatic set_frame(logic [APB_DW-1:0] c, logic [APB_DW-1:0] r);
		wait_drained();
		repeat (DRAIN_LAT) @(posedge clk);
		program_reg(REG_COLS, c);
		program_reg(REG_ROWS, r);
	endtask

	// one whole frame with random content, stray flushes and extra pixels
	task automatic run_frame(int pause_at);
		int unsigned total, flushes, c_n, i;
		c_n = model.cols_eff();
		total = c_n * model.rows_eff();
		flushes = (total < c_n + 1) ? total : c_n + 1;
		for (i = 0; i < total; i++) begin
			if (i == pause_at) wait_drained();
			if ($urandom_range(0, 19) == 0)
				send_word(FUNC_FLUSH, PIX_W'($urandom_range(0, 255)));
			send_word(FUNC_PIXEL, PIX_W'($urandom_range(0, 255)));
			counted++;
		end
		for (i = 0; i < flushes; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_word(FUNC_PIXEL, PIX_W'($urandom_range(0, 255)));
			send_word(FUNC_FLUSH, PIX_W'($urandom_range(0, 255)));
			counted++;
		end
	endtask

	initial begin
		int n;
		logic [APB_DW-1:0] c, r;
		arst_n          <= 1'b0;
		pix_ch.valid    <= 1'b0;
		pix_ch.func     <= FUNC_PIXEL;
		pix_ch.pixel_in <= '0;
		psel            <= 1'b0;
		penable         <= 1'b0;
		pwrite          <= 1'b0;
		paddr           <= '0;
		pwdata          <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero registers act as a 1x1 frame; early flush and extra pixel dropped
		set_frame(0, 0);
		send_word(FUNC_FLUSH, 8'd17);
		send_word(FUNC_PIXEL, 8'd255);
		send_word(FUNC_PIXEL, 8'd0);
		send_word(FUNC_FLUSH, 8'd0);
		send_word(FUNC_FLUSH, 8'd255);
		send_word(FUNC_PIXEL, 8'd0);
		send_word(FUNC_FLUSH, 8'd0);

		// smallest frame with an interior pixel, full-scale sum
		set_frame(3, 3);
		repeat (9) send_word(FUNC_PIXEL, 8'd255);
		repeat (4) send_word(FUNC_FLUSH, 8'd0);

		// register write in the middle of a frame restarts it
		set_frame(4, 3);
		repeat (6) send_word(FUNC_PIXEL, PIX_W'($urandom_range(0, 255)));
		set_frame(4, 3);
		run_frame(-1);

		// long receiver hold-off, then a sender pause mid-frame
		set_frame(20, 12);
		sink_hold = 1'b1;
		run_frame(120);

		// clamped row count, abandoned by the next write
		set_frame(3, 8191);
		repeat (30) send_word(FUNC_PIXEL, PIX_W'($urandom_range(0, 255)));

		// clamped column count: the start of the first row comes out, then the frame is abandoned
		set_frame(2047, 3);
		repeat (1100) begin
			send_word(FUNC_PIXEL, PIX_W'($urandom_range(0, 255)));
			counted++;
		end

		// random frames, mostly small
		set_frame(1, 1);
		while (counted < 1900) begin
			if (counted > 1500) begin
				idle_on  = 1'b0;
				stall_on = 1'b0;
			end
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 19))
					0:       c = 0;
					1, 2:    c = $urandom_range(17, 40);
					default: c = $urandom_range(1, 16);
				endcase
				case ($urandom_range(0, 19))
					0:       r = 0;
					1, 2:    r = $urandom_range(9, 20);
					default: r = $urandom_range(1, 8);
				endcase
				set_frame(c, r);
			end
			run_frame(($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : -1);
		end

		// drain, then let the pipeline settle
		pix_ch.valid <= 1'b0;
		n = 0;
		while (model.pending() != 0 && n < 50000) begin
			@(posedge clk);
			n++;
		end
		repeat (20) @(posedge clk);
		if (model.pending() != 0)
			model.note_error($sformatf("%0t: %0d expected pixels never arrived",
				$time, model.pending()));

		$display("covered %0d frames, %0d input words, %0d output pixels checked",
			model.frames, model.words, model.checked);
		$display("frames up to 40 wide, a clamped 1024-wide row, restarts, stray flushes");
		if (model.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
